### hdl/ode_step_size_controller_unit_macros.svh
// assertion helpers for the top module, the only one that includes them
`ifndef ODE_STEP_SIZE_CONTROLLER_UNIT_MACROS_SVH
`define ODE_STEP_SIZE_CONTROLLER_UNIT_MACROS_SVH

// plain property check on the block clock
`define SSC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("ssc check failed");

// implication check on the block clock
`define SSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ssc check failed");

`endif

### hdl/ssc_pkg.sv
package ssc_pkg;

    localparam int STEP_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ERR_W   = FRAC_W + 8;
    localparam int SCALE_W = FRAC_W + 3;

    localparam int ERR_K   = 10000;
    localparam int K_W     = 14;
    localparam int D_W     = ERR_W + K_W;

    // s < 2^SCALE_W, so s^4 < 2^Q_W; quotients beyond that saturate
    localparam int Q_W     = 4 * SCALE_W;
    localparam int R1_W    = Q_W / 2;
    localparam int NUM_W   = 13 + 5 * FRAC_W;
    localparam int HI_W    = NUM_W - Q_W;

    localparam logic [NUM_W-1:0]   NUM_C   = NUM_W'(6561) << (5 * FRAC_W);
    localparam logic [HI_W-1:0]    NUM_HI  = HI_W'(NUM_C >> Q_W);

    localparam logic [SCALE_W-1:0] ONE_Q     = SCALE_W'(1) << FRAC_W;
    localparam logic [SCALE_W-1:0] HALF_Q    = ONE_Q >> 1;
    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(5 * (1 << FRAC_W));
    localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'((1 << FRAC_W) / 10);
    localparam logic [SCALE_W-1:0] HYST_LOW  = SCALE_W'((9 * (1 << FRAC_W)) / 10);
    localparam logic [SCALE_W-1:0] HYST_HIGH = SCALE_W'((12 * (1 << FRAC_W)) / 10);

    typedef enum logic [0:0] {
        REG_MIN_STEP = 1'b0,
        REG_MAX_STEP = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              limited;
        logic              evalid;
        logic              fail;
    } side_t;

endpackage

### hdl/ssc_div.sv
module ssc_div
    import ssc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [D_W-1:0]   in_d,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q,
    output logic             out_ovf,
    output side_t            out_side
);

    logic             v_reg    [0:Q_W];
    logic [D_W-1:0]   d_reg    [0:Q_W];
    logic [D_W-1:0]   rem_reg  [0:Q_W];
    logic [Q_W-1:0]   q_reg    [0:Q_W];
    logic             ovf_reg  [0:Q_W];
    side_t            side_reg [0:Q_W];

    // stage zero is the entry, combinational
    always_comb begin
        v_reg[0]    = in_valid;
        d_reg[0]    = in_d;
        rem_reg[0]  = D_W'(NUM_HI);
        q_reg[0]    = '0;
        ovf_reg[0]  = (in_d <= D_W'(NUM_HI));
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [D_W:0]   trial;
        logic           ge;
        logic [D_W-1:0] rem_next;

        always_comb begin
            trial    = {rem_reg[i], NUM_C[Q_W-1-i]};
            ge       = (trial >= {1'b0, d_reg[i]});
            rem_next = ge ? D_W'(trial - {1'b0, d_reg[i]}) : trial[D_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[i+1]    <= d_reg[i];
                rem_reg[i+1]  <= rem_next;
                q_reg[i+1]    <= {q_reg[i][Q_W-2:0], ge};
                ovf_reg[i+1]  <= ovf_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign out_q     = q_reg[Q_W];
    assign out_ovf   = ovf_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

### hdl/ssc_root.sv
module ssc_root
    import ssc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [Q_W-1:0]     in_q,
    input  logic               in_ovf,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [SCALE_W-1:0] out_root,
    output logic               out_ovf,
    output side_t              out_side
);

    localparam int RA_W = R1_W + 2;
    localparam int RB_W = SCALE_W + 2;
    localparam int N_ST = R1_W + SCALE_W;

    // first square root over the quotient
    logic             av_reg    [0:R1_W];
    logic [Q_W-1:0]   ax_reg    [0:R1_W];
    logic [RA_W-1:0]  arem_reg  [0:R1_W];
    logic [R1_W-1:0]  aroot_reg [0:R1_W];
    logic             aovf_reg  [0:R1_W];
    side_t            aside_reg [0:R1_W];

    always_comb begin
        av_reg[0]    = in_valid;
        ax_reg[0]    = in_q;
        arem_reg[0]  = '0;
        aroot_reg[0] = '0;
        aovf_reg[0]  = in_ovf;
        aside_reg[0] = in_side;
    end

    for (genvar j = 0; j < R1_W; j++) begin : g_root_a
        logic [RA_W-1:0] trial;
        logic [RA_W-1:0] sub;
        logic            ge;

        always_comb begin
            trial = {arem_reg[j][RA_W-3:0], ax_reg[j][Q_W-1 -: 2]};
            sub   = {aroot_reg[j], 2'b01};
            ge    = (trial >= sub);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                av_reg[j+1] <= 1'b0;
            end else if (en) begin
                av_reg[j+1] <= av_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ax_reg[j+1]    <= {ax_reg[j][Q_W-3:0], 2'b00};
                arem_reg[j+1]  <= ge ? trial - sub : trial;
                aroot_reg[j+1] <= {aroot_reg[j][R1_W-2:0], ge};
                aovf_reg[j+1]  <= aovf_reg[j];
                aside_reg[j+1] <= aside_reg[j];
            end
        end
    end

    // second square root over the first root
    logic               bv_reg    [0:SCALE_W];
    logic [R1_W-1:0]    bx_reg    [0:SCALE_W];
    logic [RB_W-1:0]    brem_reg  [0:SCALE_W];
    logic [SCALE_W-1:0] broot_reg [0:SCALE_W];
    logic               bovf_reg  [0:SCALE_W];
    side_t              bside_reg [0:SCALE_W];

    always_comb begin
        bv_reg[0]    = av_reg[R1_W];
        bx_reg[0]    = aroot_reg[R1_W];
        brem_reg[0]  = '0;
        broot_reg[0] = '0;
        bovf_reg[0]  = aovf_reg[R1_W];
        bside_reg[0] = aside_reg[R1_W];
    end

    for (genvar k = 0; k < SCALE_W; k++) begin : g_root_b
        logic [RB_W-1:0] trial;
        logic [RB_W-1:0] sub;
        logic            ge;

        always_comb begin
            trial = {brem_reg[k][RB_W-3:0], bx_reg[k][R1_W-1 -: 2]};
            sub   = {broot_reg[k], 2'b01};
            ge    = (trial >= sub);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                bv_reg[k+1] <= 1'b0;
            end else if (en) begin
                bv_reg[k+1] <= bv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                bx_reg[k+1]    <= {bx_reg[k][R1_W-3:0], 2'b00};
                brem_reg[k+1]  <= ge ? trial - sub : trial;
                broot_reg[k+1] <= {broot_reg[k][SCALE_W-2:0], ge};
                bovf_reg[k+1]  <= bovf_reg[k];
                bside_reg[k+1] <= bside_reg[k];
            end
        end
    end

    assign out_valid = bv_reg[SCALE_W];
    assign out_root  = broot_reg[SCALE_W];
    assign out_ovf   = bovf_reg[SCALE_W];
    assign out_side  = bside_reg[SCALE_W];

endmodule

### hdl/ssc_post.sv
module ssc_post
    import ssc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [SCALE_W-1:0] in_root,
    input  logic               in_ovf,
    input  side_t              in_side,
    input  logic [STEP_W-1:0]  min_step,
    input  logic [STEP_W-1:0]  max_step,
    output logic               out_valid,
    output logic [STEP_W-1:0]  out_next,
    output logic [SCALE_W-1:0] out_scale
);

    localparam int P_W = STEP_W + SCALE_W;

    logic               v1_reg, v2_reg, v3_reg;
    logic [SCALE_W-1:0] scale1_reg, scale1_next, scale2_reg;
    logic [STEP_W-1:0]  step1_reg;
    logic               evalid1_reg, evalid2_reg;
    logic [P_W-1:0]     prod2_reg;
    logic [STEP_W-1:0]  next3_reg, next3_next;
    logic [SCALE_W-1:0] scale3_reg;
    logic [STEP_W+2:0]  hi;
    logic [STEP_W-1:0]  sat;

    // scale rules
    always_comb begin
        if (in_ovf || in_root > SCALE_MAX) begin
            scale1_next = SCALE_MAX;
        end else begin
            scale1_next = in_root;
        end
        if (scale1_next < SCALE_MIN) begin
            scale1_next = SCALE_MIN;
        end
        if (in_side.fail) begin
            if (scale1_next > HYST_LOW) begin
                scale1_next = HYST_LOW;
            end
        end else if (scale1_next > HYST_LOW && scale1_next < HYST_HIGH) begin
            scale1_next = ONE_Q;
        end
        if (in_side.limited && scale1_next > ONE_Q) begin
            scale1_next = ONE_Q;
        end
        if (!in_side.evalid) begin
            scale1_next = HALF_Q;
        end
    end

    // saturate and clamp
    always_comb begin
        hi  = prod2_reg[P_W-1:FRAC_W];
        sat = (|hi[STEP_W+2:STEP_W]) ? '1 : hi[STEP_W-1:0];
        next3_next = sat;
        if (next3_next < min_step) begin
            next3_next = min_step;
        end
        if (evalid2_reg && next3_next > max_step) begin
            next3_next = max_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scale1_reg  <= scale1_next;
            step1_reg   <= in_side.step;
            evalid1_reg <= in_side.evalid;
            prod2_reg   <= P_W'(step1_reg) * P_W'(scale1_reg);
            scale2_reg  <= scale1_reg;
            evalid2_reg <= evalid1_reg;
            next3_reg   <= next3_next;
            scale3_reg  <= scale2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_next  = next3_reg;
    assign out_scale = scale3_reg;

endmodule

### hdl/ode_step_size_controller_unit.sv
// step size controller for an embedded fourth order runge-kutta integrator
// s_ channel: one word per attempted step; tdata holds step_taken and the
// q8.16 error_estimate, tuser holds was_limited and error_valid
// m_ channel: one word per input word, in order; tdata holds next_step and
// the q3.16 applied_scale
// cfg port: cfg_we writes cfg_wdata into min_step (index 0) or max_step
// (index 1) at the clock edge; users must write only while the block is idle,
// which the block itself does not enforce; throughput is one word per cycle
// unless m_tready stalls; bit-serial pipeline: one stage for the error product,
// 76 restoring divide stages, 38 plus 19 square root stages, three output stages
// reset (synchronous, aresetn low) empties the pipeline, sets min_step to 1
// and max_step to all ones
// a stall on m_tready freezes the whole pipeline and drops s_tready, so no
// word is lost or repeated
`include "ode_step_size_controller_unit_macros.svh"

module ode_step_size_controller_unit
    import ssc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [55:0]        s_tdata,   // step_taken, error_estimate
    input  logic [1:0]         s_tuser,   // was_limited, error_valid
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // next_step, applied_scale, zero fill
    input  logic               cfg_we,
    input  cfg_idx_t           cfg_addr,
    input  logic [STEP_W-1:0]  cfg_wdata
);

    logic [STEP_W-1:0]  min_step_reg, max_step_reg;
    logic               en;
    logic               a_v_reg;
    logic [D_W-1:0]     a_d_reg;
    side_t              a_side_reg, a_side_next;
    logic [ERR_W-1:0]   err;

    logic               dv, rv, pv;
    logic [Q_W-1:0]     dq;
    logic               dovf, rovf;
    side_t              dside, rside;
    logic [SCALE_W-1:0] root;
    logic [STEP_W-1:0]  next_step;
    logic [SCALE_W-1:0] applied_scale;

    assign en       = !pv || m_tready;
    assign s_tready = en;
    assign err      = s_tdata[STEP_W +: ERR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_step_reg <= STEP_W'(1);
            max_step_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MIN_STEP: min_step_reg <= cfg_wdata;
                REG_MAX_STEP: max_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        a_side_next.step    = s_tdata[STEP_W-1:0];
        a_side_next.limited = s_tuser[0];
        a_side_next.evalid  = s_tuser[1];
        a_side_next.fail    = (err > ERR_W'(ONE_Q));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_d_reg    <= D_W'(err) * D_W'(ERR_K);
            a_side_reg <= a_side_next;
        end
    end

    ssc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_v_reg),
        .in_d     (a_d_reg),
        .in_side  (a_side_reg),
        .out_valid(dv),
        .out_q    (dq),
        .out_ovf  (dovf),
        .out_side (dside)
    );

    ssc_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv),
        .in_q     (dq),
        .in_ovf   (dovf),
        .in_side  (dside),
        .out_valid(rv),
        .out_root (root),
        .out_ovf  (rovf),
        .out_side (rside)
    );

    ssc_post u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rv),
        .in_root  (root),
        .in_ovf   (rovf),
        .in_side  (rside),
        .min_step (min_step_reg),
        .max_step (max_step_reg),
        .out_valid(pv),
        .out_next (next_step),
        .out_scale(applied_scale)
    );

    assign m_tvalid = pv;
    assign m_tdata  = {5'b0, applied_scale, next_step};

    `SSC_ASSERT_IMP(a_scale_high, m_tvalid, applied_scale <= SCALE_MAX)
    `SSC_ASSERT_IMP(a_scale_low, m_tvalid, applied_scale >= SCALE_MIN)
    `SSC_ASSERT_IMP(a_step_range, m_tvalid,
                    next_step >= min_step_reg || next_step == max_step_reg)
    `SSC_ASSERT_IMP(a_hold_on_stall, m_tvalid && !m_tready,
                    ##1 (m_tvalid && $stable(m_tdata)))

endmodule

### tb/ssc_step_checker.sv
module ssc_step_checker
    import ssc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [55:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [55:0]       m_tdata,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_addr,
    input  logic [STEP_W-1:0] cfg_wdata,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [STEP_W-1:0]  next;
    } step_advice_t;

    logic [STEP_W-1:0] lim_min;
    logic [STEP_W-1:0] lim_max;
    step_advice_t      advice_q[$];

    initial fail_count = 0;
    assign pending = advice_q.size();

    // largest s <= SCALE_MAX with 10000 * s^4 * e <= 6561 * 2^80, floored at SCALE_MIN
    function automatic logic [SCALE_W-1:0] root_scale(input logic [ERR_W-1:0] e);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        logic [127:0] lhs;
        logic [127:0] rhs;
        lo = '0;
        hi = 128'(SCALE_MAX);
        rhs = 128'(6561) << (5 * FRAC_W);
        if (e == 0) begin
            return SCALE_MAX;
        end
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = mid * mid * mid * mid * 128'(e) * 128'(ERR_K);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (lo < 128'(SCALE_MIN)) begin
            lo = 128'(SCALE_MIN);
        end
        return SCALE_W'(lo);
    endfunction

    function automatic step_advice_t advise(input logic [STEP_W-1:0] step,
                                            input logic lim, input logic ev,
                                            input logic [ERR_W-1:0] e);
        step_advice_t r;
        logic [SCALE_W-1:0] s;
        logic [63:0] prod;
        logic [STEP_W-1:0] nx;
        if (!ev) begin
            nx = step >> 1;
            if (nx < lim_min) begin
                nx = lim_min;
            end
            r.next = nx;
            r.scale = HALF_Q;
            return r;
        end
        s = root_scale(e);
        if (e > ERR_W'(ONE_Q)) begin
            if (s > HYST_LOW) begin
                s = HYST_LOW;
            end
        end else if (s > HYST_LOW && s < HYST_HIGH) begin
            s = ONE_Q;
        end
        if (lim && s > ONE_Q) begin
            s = ONE_Q;
        end
        prod = (64'(step) * 64'(s)) >> FRAC_W;
        nx = (prod > 64'({STEP_W{1'b1}})) ? {STEP_W{1'b1}} : prod[STEP_W-1:0];
        if (nx < lim_min) begin
            nx = lim_min;
        end
        if (nx > lim_max) begin
            nx = lim_max;
        end
        r.next = nx;
        r.scale = s;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        step_advice_t w;
        if (!aresetn) begin
            lim_min <= STEP_W'(1);
            lim_max <= {STEP_W{1'b1}};
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_MIN_STEP) begin
                    lim_min <= cfg_wdata;
                end else if (cfg_addr == REG_MAX_STEP) begin
                    lim_max <= cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                advice_q.push_back(advise(s_tdata[31:0], s_tuser[0], s_tuser[1],
                                          s_tdata[55:32]));
            end
            if (m_tvalid && m_tready) begin
                if (advice_q.size() == 0) begin
                    report("unexpected word next_step", 64'(m_tdata[31:0]), '0);
                end else begin
                    w = advice_q.pop_front();
                    if (m_tdata[31:0] != w.next) begin
                        report("next_step", 64'(m_tdata[31:0]), 64'(w.next));
                    end
                    if (m_tdata[50:32] != w.scale) begin
                        report("applied_scale", 64'(m_tdata[50:32]), 64'(w.scale));
                    end
                    if (m_tdata[55:51] != 0) begin
                        report("tdata fill", 64'(m_tdata[55:51]), '0);
                    end
                end
            end
        end
    end

endmodule

### tb/tb_ode_step_size_controller_unit.sv
module tb_ode_step_size_controller_unit;
    import ssc_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [55:0]       s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [55:0]       m_tdata;
    logic              cfg_we;
    cfg_idx_t          cfg_addr;
    logic [STEP_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                idle_mode;
    logic              hold_req;
    logic              hold_done;
    int                hold_left;

    ode_step_size_controller_unit DUT (.*);

    ssc_step_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver side, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
            if (hold_left == 1) begin
                hold_done <= 1'b1;
            end
        end else if (idle_mode == 2 || idle_mode == 3) begin
            m_tready <= ($urandom_range(99) >= (idle_mode == 2 ? 84 : 24));
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic set_limits(input logic [STEP_W-1:0] lo, input logic [STEP_W-1:0] hi);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_MIN_STEP;
        cfg_wdata <= lo;
        @(negedge aclk);
        cfg_addr <= REG_MAX_STEP;
        cfg_wdata <= hi;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input logic [31:0] step, input logic lim, input logic ev,
                             input logic [23:0] err);
        int pct;
        pct = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 24 : 0;
        if (pct > 0 && $urandom_range(99) < pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < pct) begin
                @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {err, step};
        s_tuser <= {ev, lim};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic random_word();
        logic [31:0] step;
        logic [23:0] err;
        case ($urandom_range(3))
            0: step = $urandom;
            1: step = $urandom_range(4095);
            default: step = $urandom_range(32'h00ff_ffff);
        endcase
        case ($urandom_range(4))
            0: err = 24'($urandom);
            1: err = 24'($urandom_range(24'h02_0000));
            2: err = 24'($urandom_range(255));
            3: err = 24'(32'h01_0000 + $urandom_range(64) - 32);
            default: err = (($urandom_range(9) == 0) ? 24'd0 :
                            24'($urandom_range(24'h00_ffff)));
        endcase
        send_word(step, 1'($urandom_range(1)), $urandom_range(9) != 0, err);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (150) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_MIN_STEP;
        cfg_wdata = '0;
        idle_mode = 0;
        hold_req = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset limits first
        send_word(32'hffff_ffff, 1'b0, 1'b1, 24'd0);
        send_word(32'h0000_0000, 1'b0, 1'b1, 24'd0);
        send_word(32'h0000_1000, 1'b0, 1'b1, 24'hff_ffff);
        send_word(32'h0000_1000, 1'b1, 1'b1, 24'd1);
        send_word(32'h0001_0000, 1'b0, 1'b1, 24'h01_0000);
        send_word(32'h0001_0000, 1'b0, 1'b1, 24'h01_0001);
        send_word(32'h0001_0000, 1'b0, 1'b1, 24'h00_8000);
        send_word(32'h0001_0000, 1'b1, 1'b1, 24'h00_8000);
        send_word(32'h0001_0000, 1'b0, 1'b1, 24'h00_d000);
        send_word(32'h0001_0000, 1'b1, 1'b1, 24'h00_0100);
        send_word(32'h0000_0001, 1'b1, 1'b0, 24'hff_ffff);
        send_word(32'hffff_ffff, 1'b0, 1'b0, 24'h00_0000);
        send_word(32'h8000_0000, 1'b0, 1'b1, 24'h00_0001);
        send_word(32'h0000_0005, 1'b0, 1'b1, 24'h10_0000);
        drain();
        set_limits(32'd1000, 32'd5000);
        send_word(32'd100, 1'b0, 1'b0, 24'd0);
        send_word(32'd100, 1'b0, 1'b1, 24'd0);
        send_word(32'd4000, 1'b0, 1'b1, 24'd0);
        send_word(32'd1500, 1'b0, 1'b1, 24'h80_0000);
        drain();
        set_limits(32'hffff_ffff, 32'd0);
        send_word(32'd12345, 1'b0, 1'b1, 24'h00_4000);
        send_word(32'd12345, 1'b0, 1'b0, 24'h00_4000);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin lo = 32'd1; hi = 32'hffff_ffff; end
                1: begin lo = 32'd0; hi = 32'd0; end
                2: begin lo = 32'hffff_ffff; hi = 32'hffff_ffff; end
                3: begin lo = 32'd0; hi = 32'hffff_ffff; end
                4: begin lo = $urandom_range(2000); hi = lo + $urandom_range(1 << 20); end
                default: begin lo = $urandom_range(32'hffff); hi = $urandom; end
            endcase
            set_limits(lo, hi);
            idle_mode = p % 4;
            if (p == 4) begin
                @(negedge aclk);
                hold_req = 1'b1;
            end
            for (int i = 0; i < 160; i++) begin
                random_word();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### ode_step_size_controller_unit.f
+incdir+hdl
hdl/ssc_pkg.sv
hdl/ssc_div.sv
hdl/ssc_root.sv
hdl/ssc_post.sv
hdl/ode_step_size_controller_unit.sv
tb/ssc_step_checker.sv
tb/tb_ode_step_size_controller_unit.sv
